FILE: rtl/stlt_pkg.sv
package stlt_pkg;

  localparam int LEVEL_W    = 10;
  localparam int POS_W      = 6;
  localparam int IDX_W      = 2;
  localparam int COIL_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEPS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MIN_START = 1'd1;

  localparam logic [POS_W-1:0]   SCAN_STEPS_RST     = 6'd20;
  localparam logic [LEVEL_W-1:0] SCAN_MIN_START_RST = 10'd255;

  localparam logic [COIL_W-1:0] COIL_0 = 4'b0011;
  localparam logic [COIL_W-1:0] COIL_1 = 4'b0110;
  localparam logic [COIL_W-1:0] COIL_2 = 4'b1100;
  localparam logic [COIL_W-1:0] COIL_3 = 4'b1001;

  localparam logic IN_KIND_START  = 1'b0;
  localparam logic IN_KIND_SAMPLE = 1'b1;

  typedef logic [COIL_W-1:0] coil_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic ld_start;
    logic scan_sample;
    logic track_sample;
    logic step;
    logic turn;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic cnt_zero;
    logic cnt_one;
  } dp_sts_t;

  function automatic coil_t coil_of(input idx_t idx);
    coil_t c;
    unique case (idx)
      2'd0:    c = COIL_0;
      2'd1:    c = COIL_1;
      2'd2:    c = COIL_2;
      default: c = COIL_3;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/stlt_cfg.sv
module stlt_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [stlt_pkg::POS_W-1:0]       scan_steps,
  output logic [stlt_pkg::LEVEL_W-1:0]     scan_min_start
);

  logic [stlt_pkg::POS_W-1:0]   scan_steps_r,     scan_steps_nxt;
  logic [stlt_pkg::LEVEL_W-1:0] scan_min_start_r, scan_min_start_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    scan_steps_nxt     = scan_steps_r;
    scan_min_start_nxt = scan_min_start_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        stlt_pkg::CFG_SCAN_STEPS:     scan_steps_nxt = cfg_data[stlt_pkg::POS_W-1:0];
        stlt_pkg::CFG_SCAN_MIN_START: scan_min_start_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_steps_r     <= stlt_pkg::SCAN_STEPS_RST;
      scan_min_start_r <= stlt_pkg::SCAN_MIN_START_RST;
    end else begin
      scan_steps_r     <= scan_steps_nxt;
      scan_min_start_r <= scan_min_start_nxt;
    end
  end

  assign scan_steps     = scan_steps_r;
  assign scan_min_start = scan_min_start_r;

endmodule

FILE: rtl/stlt_dp.sv
module stlt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stlt_pkg::dp_cmd_t                cmd,
  output stlt_pkg::dp_sts_t                sts,
  input  logic [stlt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [stlt_pkg::POS_W-1:0]       scan_steps,
  input  logic [stlt_pkg::LEVEL_W-1:0]     scan_min_start,
  output logic [stlt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int LW = stlt_pkg::LEVEL_W;
  localparam int PW = stlt_pkg::POS_W;

  stlt_pkg::idx_t idx_r, idx_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [LW-1:0]  low_lvl_r, low_lvl_nxt;
  logic [PW-1:0]  low_pos_r, low_pos_nxt;
  logic [PW-1:0]  cnt_r, cnt_nxt;
  logic           last_dir_r, last_dir_nxt;
  logic           dir_r, dir_nxt;
  logic           end_r, end_nxt;

  logic [LW-1:0]  right_lvl;
  logic [LW-1:0]  left_lvl;
  logic [PW-1:0]  limit;
  logic [PW-1:0]  pos_inc;
  logic [PW-1:0]  low_pos_sel;
  logic           below;

  assign right_lvl   = in_tdata[LW-1:0];
  assign left_lvl    = in_tdata[2*LW-1:LW];
  assign limit       = (scan_steps == '0) ? PW'(1) : scan_steps;
  assign pos_inc     = pos_r + PW'(1);
  assign below       = right_lvl < low_lvl_r;
  assign low_pos_sel = below ? pos_r : low_pos_r;

  always_comb begin
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    low_lvl_nxt  = low_lvl_r;
    low_pos_nxt  = low_pos_r;
    cnt_nxt      = cnt_r;
    last_dir_nxt = last_dir_r;
    dir_nxt      = dir_r;
    end_nxt      = end_r;
    if (cmd.ld_start) begin
      pos_nxt     = '0;
      low_lvl_nxt = scan_min_start;
      low_pos_nxt = '0;
    end
    if (cmd.scan_sample) begin
      if (below) begin
        low_lvl_nxt = right_lvl;
      end
      low_pos_nxt = low_pos_sel;
      pos_nxt     = pos_inc;
      end_nxt     = pos_inc >= limit;
      cnt_nxt     = pos_r - low_pos_sel;
      dir_nxt     = 1'b1;
    end
    if (cmd.track_sample) begin
      if (left_lvl > right_lvl) begin
        if (!last_dir_r) begin
          idx_nxt = idx_r + stlt_pkg::IDX_W'(1);
        end
        dir_nxt      = 1'b1;
        last_dir_nxt = 1'b1;
      end else begin
        if (last_dir_r) begin
          idx_nxt = idx_r - stlt_pkg::IDX_W'(1);
        end
        dir_nxt      = 1'b0;
        last_dir_nxt = 1'b0;
      end
    end
    if (cmd.step) begin
      idx_nxt = dir_r ? idx_r + stlt_pkg::IDX_W'(1) : idx_r - stlt_pkg::IDX_W'(1);
      cnt_nxt = cnt_r - PW'(1);
    end
    if (cmd.turn) begin
      dir_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      pos_r      <= '0;
      low_lvl_r  <= '0;
      low_pos_r  <= '0;
      cnt_r      <= '0;
      last_dir_r <= 1'b0;
      dir_r      <= 1'b0;
      end_r      <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      pos_r      <= pos_nxt;
      low_lvl_r  <= low_lvl_nxt;
      low_pos_r  <= low_pos_nxt;
      cnt_r      <= cnt_nxt;
      last_dir_r <= last_dir_nxt;
      dir_r      <= dir_nxt;
      end_r      <= end_nxt;
    end
  end

  assign sts.scan_end = end_r;
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.cnt_one  = cnt_r == PW'(1);

  assign out_tdata = {(stlt_pkg::OUT_DATA_W - stlt_pkg::COIL_W - 1)'(0), dir_r,
                      stlt_pkg::coil_of(idx_r)};

endmodule

FILE: rtl/stlt_ctrl.sv
module stlt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_tlast,
  output stlt_pkg::dp_cmd_t cmd,
  input  stlt_pkg::dp_sts_t sts
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_TRACK     = 3'd2;
  localparam logic [2:0] ST_SCAN_OUT  = 3'd3;
  localparam logic [2:0] ST_RET_OUT   = 3'd4;
  localparam logic [2:0] ST_TRACK_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       in_xfer;
  logic       out_xfer;
  logic       is_sample;

  assign is_sample = in_tuser == stlt_pkg::IN_KIND_SAMPLE;
  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_SCAN) || (state_r == ST_TRACK);
  assign out_tvalid = (state_r == ST_SCAN_OUT) || (state_r == ST_RET_OUT) ||
                      (state_r == ST_TRACK_OUT);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_tlast = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && !is_sample) begin
          cmd.ld_start = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (in_xfer && is_sample) begin
          cmd.scan_sample = 1'b1;
          state_nxt       = ST_SCAN_OUT;
        end
      end
      ST_TRACK: begin
        if (in_xfer && is_sample) begin
          cmd.track_sample = 1'b1;
          state_nxt        = ST_TRACK_OUT;
        end
      end
      ST_SCAN_OUT: begin
        out_tlast = !sts.scan_end || sts.cnt_zero;
        if (out_xfer) begin
          priority if (!sts.scan_end) begin
            cmd.step  = 1'b1;
            state_nxt = ST_SCAN;
          end else if (sts.cnt_zero) begin
            cmd.turn  = 1'b1;
            state_nxt = ST_TRACK;
          end else begin
            cmd.turn  = 1'b1;
            state_nxt = ST_RET_OUT;
          end
        end
      end
      ST_RET_OUT: begin
        out_tlast = sts.cnt_one;
        if (out_xfer) begin
          cmd.step = 1'b1;
          if (sts.cnt_one) begin
            state_nxt = ST_TRACK;
          end
        end
      end
      ST_TRACK_OUT: begin
        out_tlast = 1'b1;
        if (out_xfer) begin
          cmd.step  = 1'b1;
          state_nxt = ST_TRACK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/stepper_light_seeking_tracker_top.sv
// Full-step stepper light tracker. In idle, a start transfer (tuser 0) begins
// a scan; each sample transfer (tuser 1) during the scan records the right
// level, keeps the darkest position and yields one clockwise step, and the
// last scan sample also yields the counter-clockwise return run to the darkest
// spot, one step per cycle while out_tready is high, with tlast on the final
// one. After the scan every sample yields one step toward the darker sensor.
// A start yields no step; a sample yields up to 63 step results (after the
// final scan sample), and input is held off until the last step of a run has
// been taken. Config writes are taken every cycle and should land only while
// no run is pending.
module stepper_light_seeking_tracker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stlt_pkg::IN_DATA_W-1:0]   in_tdata,   // right_level, left_level, pad
  input  logic                             in_tuser,   // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stlt_pkg::OUT_DATA_W-1:0]  out_tdata,  // coil_pattern, clockwise, pad
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stlt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  stlt_pkg::dp_cmd_t            cmd;
  stlt_pkg::dp_sts_t            sts;
  logic [stlt_pkg::POS_W-1:0]   scan_steps;
  logic [stlt_pkg::LEVEL_W-1:0] scan_min_start;

  stlt_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .scan_steps     (scan_steps),
    .scan_min_start (scan_min_start)
  );

  stlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  stlt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_tdata       (in_tdata),
    .scan_steps     (scan_steps),
    .scan_min_start (scan_min_start),
    .out_tdata      (out_tdata)
  );

endmodule

FILE: rtl/stlt_checker.sv
module stlt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [stlt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a step is pending");

  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == stlt_pkg::IN_KIND_START)) |=> !out_tvalid)
    else $error("start transfer produced a step");

  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("gap inside a step run");

  a_coil_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] == stlt_pkg::COIL_0 || out_tdata[3:0] == stlt_pkg::COIL_1 ||
                    out_tdata[3:0] == stlt_pkg::COIL_2 || out_tdata[3:0] == stlt_pkg::COIL_3))
    else $error("illegal coil pattern");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output changed");

endmodule

bind stepper_light_seeking_tracker_top stlt_checker u_stlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: tb/sv/tb_stepper_light_seeking_tracker_top.sv
module tb_stepper_light_seeking_tracker_top;
  import stlt_pkg::*;

  localparam int HOLD_LEN   = 150;
  localparam int WDOG_LIMIT = 1000;
  localparam int SETTLE     = 4;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef enum logic [1:0] {MODE_IDLE, MODE_SCAN, MODE_TRACK} track_mode_e;
  typedef struct {
    coil_t coil;
    bit    cw;
    bit    is_last;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stepper_light_seeking_tracker_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted state of the tracker
  coil_t       coil_lut [4] = '{COIL_0, COIL_1, COIL_2, COIL_3};
  track_mode_e mode = MODE_IDLE;
  idx_t        coil_idx = '0;
  pos_t        scan_pos = '0;
  level_t      low_level = '0;
  pos_t        low_pos = '0;
  bit          last_cw = 1'b0;
  pos_t        steps_cfg = SCAN_STEPS_RST;
  level_t      min_cfg = SCAN_MIN_START_RST;

  step_t step_q [$];
  step_t got_step;
  int    errors = 0;
  int    items_sent = 0;
  int    steps_checked = 0;
  int    idle_pct = 26;
  int    scan_kind = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    quiet_cycles = 0;

  function automatic void emit_step(bit cw);
    step_t s;
    s.coil = coil_lut[coil_idx];
    s.cw = cw;
    s.is_last = 1'b0;
    step_q.push_back(s);
    if (cw) coil_idx = coil_idx + 2'd1;
    else coil_idx = coil_idx - 2'd1;
  endfunction

  function automatic void predict_steps(logic cmd, level_t right, level_t left);
    int    lim;
    int    back;
    int    n0;
    step_t s;
    n0 = step_q.size();
    case (mode)
      MODE_SCAN: if (cmd == IN_KIND_SAMPLE) begin
        lim = (steps_cfg == 0) ? 1 : int'(steps_cfg);
        if (right < low_level) begin
          low_level = right;
          low_pos = scan_pos;
        end
        emit_step(1'b1);
        scan_pos = scan_pos + 6'd1;
        if (int'(scan_pos) >= lim) begin
          back = int'(scan_pos) - 1 - int'(low_pos);
          coil_idx = coil_idx - 2'd1;
          repeat (back) emit_step(1'b0);
          mode = MODE_TRACK;
        end
      end
      MODE_TRACK: if (cmd == IN_KIND_SAMPLE) begin
        if (left > right) begin
          if (!last_cw) coil_idx = coil_idx + 2'd1;
          emit_step(1'b1);
          last_cw = 1'b1;
        end else begin
          if (last_cw) coil_idx = coil_idx - 2'd1;
          emit_step(1'b0);
          last_cw = 1'b0;
        end
      end
      default: if (cmd == IN_KIND_START) begin
        mode = MODE_SCAN;
        scan_pos = '0;
        low_level = min_cfg;
        low_pos = '0;
      end
    endcase
    if (step_q.size() > n0) begin
      s = step_q.pop_back();
      s.is_last = 1'b1;
      step_q.push_back(s);
    end
  endfunction

  function automatic level_t rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return level_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // result side: ready generation and checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (step_q.size() == 0) begin
        $display("%0t: unexpected step, expected none, actual tdata=%h tlast=%b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        got_step = step_q.pop_front();
        if (out_tdata[COIL_W-1:0] !== got_step.coil) begin
          $display("%0t: coil_pattern expected %b actual %b",
                   $time, got_step.coil, out_tdata[COIL_W-1:0]);
          errors++;
        end
        if (out_tdata[COIL_W] !== got_step.cw) begin
          $display("%0t: clockwise expected %b actual %b",
                   $time, got_step.cw, out_tdata[COIL_W]);
          errors++;
        end
        if (out_tlast !== got_step.is_last) begin
          $display("%0t: last_of_run expected %b actual %b",
                   $time, got_step.is_last, out_tlast);
          errors++;
        end
        steps_checked++;
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic pause_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(logic cmd, level_t right, level_t left);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) pause_input(gap);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, left, right};
    do @(posedge clk); while (!in_tready);
    predict_steps(cmd, right, left);
    items_sent++;
  endtask

  task automatic wait_drained();
    pause_input(1);
    while (step_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SCAN_STEPS) steps_cfg = val[POS_W-1:0];
    else min_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_idle_ignore();
    send_item(IN_KIND_SAMPLE, '0, '0);
    send_item(IN_KIND_SAMPLE, '1, '1);
    send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
  endtask

  task automatic test_config_sweep();
    write_cfg(CFG_SCAN_STEPS, '0);
    write_cfg(CFG_SCAN_MIN_START, '0);
    write_cfg(CFG_SCAN_STEPS, '1);
    write_cfg(CFG_SCAN_MIN_START, '1);
    send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
  endtask

  // one scan per run: deepest return, shortened scan, or no dark sample
  task automatic test_scan();
    int     n_scan;
    int     i;
    int     new_len;
    level_t r;
    scan_kind = $urandom_range(0, 2);
    case (scan_kind)
      0: begin
        n_scan = 63;
        write_cfg(CFG_SCAN_STEPS, 10'h3FF);
        write_cfg(CFG_SCAN_MIN_START, 10'h3FF);
      end
      1: begin
        n_scan = $urandom_range(4, 30);
        write_cfg(CFG_SCAN_STEPS, 10'd63);
        write_cfg(CFG_SCAN_MIN_START, CFG_DATA_W'($urandom_range(0, 1023)));
      end
      default: begin
        n_scan = $urandom_range(1, 40);
        write_cfg(CFG_SCAN_STEPS, CFG_DATA_W'(n_scan + 64 * $urandom_range(0, 15)));
        write_cfg(CFG_SCAN_MIN_START, '0);
      end
    endcase
    send_item(IN_KIND_START, rand_level(), rand_level());
    for (i = 0; i < n_scan; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(IN_KIND_START, rand_level(), rand_level());
      r = (scan_kind == 0 && i == 0) ? level_t'(0) : rand_level();
      send_item(IN_KIND_SAMPLE, r, rand_level());
    end
    if (scan_kind == 1) begin
      new_len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, n_scan);
      write_cfg(CFG_SCAN_STEPS, CFG_DATA_W'(new_len));
      send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
    end
  endtask

  task automatic test_track_directed();
    send_item(IN_KIND_SAMPLE, '0, '0);
    send_item(IN_KIND_SAMPLE, '0, '1);
    send_item(IN_KIND_SAMPLE, '1, '0);
    send_item(IN_KIND_SAMPLE, '1, '1);
    send_item(IN_KIND_SAMPLE, 10'd5, 10'd6);
    send_item(IN_KIND_SAMPLE, 10'd6, 10'd6);
    send_item(IN_KIND_START, rand_level(), rand_level());
    send_item(IN_KIND_SAMPLE, 10'd511, 10'd512);
    send_item(IN_KIND_SAMPLE, 10'd512, 10'd511);
  endtask

  task automatic test_backpressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 12; i++)
      send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
  endtask

  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 6; i++) send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
    wait_drained();
    pause_input(30);
    for (i = 0; i < 6; i++) send_item(IN_KIND_SAMPLE, rand_level(), rand_level());
  endtask

  task automatic test_track_random();
    int     i;
    level_t r;
    for (i = 0; i < 200; i++) begin
      idle_pct = (i >= 60 && i < 120) ? 0 : 26;
      if (i == 150) begin
        write_cfg(CFG_SCAN_STEPS, CFG_DATA_W'($urandom_range(0, 1023)));
        write_cfg(CFG_SCAN_MIN_START, CFG_DATA_W'($urandom_range(0, 1023)));
      end
      r = rand_level();
      case ($urandom_range(0, 11))
        0: send_item(IN_KIND_START, r, rand_level());
        1, 2: send_item(IN_KIND_SAMPLE, r, r);
        default: send_item(IN_KIND_SAMPLE, r, rand_level());
      endcase
    end
    idle_pct = 26;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ignore();
    test_config_sweep();
    test_scan();
    test_track_directed();
    test_backpressure();
    test_drain_pause();
    test_track_random();
    pause_input(1);
    while (step_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items (scan variant %0d), checked %0d coil steps.",
             items_sent, scan_kind, steps_checked);
    $display("Covered idle, scan with return run, tracking, stalls and register writes.");
    if (errors == 0 && step_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: stepper_light_seeking_tracker_top.f
rtl/stlt_pkg.sv
rtl/stlt_cfg.sv
rtl/stlt_dp.sv
rtl/stlt_ctrl.sv
rtl/stepper_light_seeking_tracker_top.sv
rtl/stlt_checker.sv
tb/sv/tb_stepper_light_seeking_tracker_top.sv
